// ----- hdl/pmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types, constants and helpers for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int COORD_BITS   = 12;   // pointer register width, 9..16
    localparam int FIELD_BITS   = 12;   // reported position field width
    localparam int SIZE_BITS    = 13;   // screen size register width
    localparam int CFG_IDX_BITS = 1;
    localparam int CMP_BITS     = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;

    localparam logic [CMP_BITS-1:0]  COORD_LIM    = CMP_BITS'(1) << COORD_BITS;
    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);
    localparam logic [7:0]           SYNC_BIT     = 8'h08;
    localparam logic [2:0]           BUTTON_MASK  = 3'h7;

    typedef enum logic [1:0] {
        OP_ARM,
        OP_BYTE,
        OP_READ,
        OP_NONE
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] centre;
    } axis_lim_t;

    // Largest legal coordinate and centre point for one screen axis.
    function automatic axis_lim_t axis_limits(input logic [SIZE_BITS-1:0] size);
        logic [CMP_BITS-1:0] wide;
        axis_lim_t           r;
        wide = CMP_BITS'(size);
        r    = '0;
        if (size == '0) begin
            r.top    = '0;
            r.centre = '0;
        end else if (wide > COORD_LIM) begin
            r.top                     = '1;
            r.centre                  = '0;
            r.centre[COORD_BITS-1]    = 1'b1;
        end else begin
            r.top    = COORD_BITS'(wide - CMP_BITS'(1));
            r.centre = COORD_BITS'(wide >> 1);
        end
        return r;
    endfunction

    // Apply a signed byte offset and clamp to 0..top.
    function automatic logic [COORD_BITS-1:0] clamp_step(
        input logic [COORD_BITS-1:0] cur,
        input logic [7:0]            delta,
        input logic                  negate,
        input logic [COORD_BITS-1:0] top
    );
        logic signed [COORD_BITS+1:0] base;
        logic signed [COORD_BITS+1:0] offs;
        logic signed [COORD_BITS+1:0] sum;
        logic signed [COORD_BITS+1:0] lim;
        base = signed'({2'b00, cur});
        offs = (COORD_BITS + 2)'(signed'(delta));
        lim  = signed'({2'b00, top});
        sum  = negate ? (base - offs) : (base + offs);
        if (sum < 0) begin
            return '0;
        end else if (sum > lim) begin
            return top;
        end
        return sum[COORD_BITS-1:0];
    endfunction

    // Report a coordinate in the fixed-width position field.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [COORD_BITS-1:0] c);
        logic [COORD_BITS+FIELD_BITS-1:0] t;
        t = (COORD_BITS + FIELD_BITS)'(c);
        return t[FIELD_BITS-1:0];
    endfunction

endpackage

// ----- hdl/pmt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_in_if
// Command channel: valid/ready handshake with operation and mouse byte.
// ----------------------------------------------------------------------------
interface pmt_in_if
    import pmt_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// ----- hdl/pmt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_out_if
// Response channel: valid/ready handshake with pointer state.
// ----------------------------------------------------------------------------
interface pmt_out_if
    import pmt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] pos_x;
    logic [FIELD_BITS-1:0] pos_y;
    logic [2:0]            button_bits;
    logic                  was_updated;

    modport source (output valid, output pos_x, output pos_y, output button_bits,
                    output was_updated, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input button_bits,
                    input was_updated, output ready);
endinterface

// ----- hdl/pmt_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_in_stage
// Input register: capture one command word, hold it until the tracker takes it.
// ----------------------------------------------------------------------------
module pmt_in_stage
    import pmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pmt_in_if.sink    cmd,
    output item_t     item,
    output logic      item_valid,
    input  logic      item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign cmd.ready  = !valid_reg || item_take;
    assign accept     = cmd.valid && cmd.ready;
    assign valid_next = accept || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation <= op_t'(cmd.operation);
            item_reg.data_byte <= cmd.data_byte;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ----- hdl/pmt_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_tracker
// Packet assembly, clamped pointer update and registered read response.
// ----------------------------------------------------------------------------
module pmt_tracker
    import pmt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  item_t                item,
    input  logic                 item_valid,
    output logic                 item_take,
    input  logic [SIZE_BITS-1:0] screen_width,
    input  logic [SIZE_BITS-1:0] screen_height,
    pmt_out_if.source            rsp
);

    logic                  armed_reg,       armed_next;
    logic [1:0]            byte_count_reg,  byte_count_next;
    logic [COORD_BITS-1:0] cursor_x_reg,    cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg,    cursor_y_next;
    logic [2:0]            buttons_reg,     buttons_next;
    logic                  update_flag_reg, update_flag_next;
    logic                  out_valid_reg,   out_valid_next;
    logic [2:0]            first_btn_reg;
    logic [7:0]            dx_byte_reg;
    logic [FIELD_BITS-1:0] pos_x_reg;
    logic [FIELD_BITS-1:0] pos_y_reg;
    logic [2:0]            btn_out_reg;
    logic                  upd_out_reg;

    axis_lim_t lim_x;
    axis_lim_t lim_y;
    logic      is_read;
    logic      load_first;
    logic      load_dx;

    assign lim_x     = axis_limits(screen_width);
    assign lim_y     = axis_limits(screen_height);
    assign is_read   = (item.operation == OP_READ);
    // A read needs a free result slot; everything else only touches state.
    assign item_take = item_valid && (!is_read || !out_valid_reg || rsp.ready);

    always_comb
    begin
        armed_next       = armed_reg;
        byte_count_next  = byte_count_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        buttons_next     = buttons_reg;
        update_flag_next = update_flag_reg;
        load_first       = 1'b0;
        load_dx          = 1'b0;
        if (item_take)
        begin
            unique case (item.operation)
                OP_ARM:
                begin
                    cursor_x_next   = lim_x.centre;
                    cursor_y_next   = lim_y.centre;
                    buttons_next    = '0;
                    byte_count_next = 2'd0;
                    armed_next      = 1'b1;
                end
                OP_BYTE:
                begin
                    if (armed_reg)
                    begin
                        priority case (byte_count_reg)
                            2'd0:
                            begin
                                if ((item.data_byte & SYNC_BIT) != 8'h00)
                                begin
                                    load_first      = 1'b1;
                                    byte_count_next = 2'd1;
                                end
                            end
                            2'd1:
                            begin
                                load_dx         = 1'b1;
                                byte_count_next = 2'd2;
                            end
                            default:
                            begin
                                cursor_x_next    = clamp_step(cursor_x_reg, dx_byte_reg,
                                                              1'b0, lim_x.top);
                                cursor_y_next    = clamp_step(cursor_y_reg, item.data_byte,
                                                              1'b1, lim_y.top);
                                buttons_next     = first_btn_reg & BUTTON_MASK;
                                update_flag_next = 1'b1;
                                byte_count_next  = 2'd0;
                            end
                        endcase
                    end
                end
                OP_READ:
                begin
                    update_flag_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid_next = (out_valid_reg && !rsp.ready) || (item_take && is_read);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            byte_count_reg  <= 2'd0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            buttons_reg     <= '0;
            update_flag_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            armed_reg       <= armed_next;
            byte_count_reg  <= byte_count_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            buttons_reg     <= buttons_next;
            update_flag_reg <= update_flag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_first)
        begin
            first_btn_reg <= item.data_byte[2:0];
        end
        if (load_dx)
        begin
            dx_byte_reg <= item.data_byte;
        end
        if (item_take && is_read)
        begin
            pos_x_reg   <= to_field(cursor_x_reg);
            pos_y_reg   <= to_field(cursor_y_reg);
            btn_out_reg <= buttons_reg;
            upd_out_reg <= update_flag_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pos_x       = pos_x_reg;
    assign rsp.pos_y       = pos_y_reg;
    assign rsp.button_bits = btn_out_reg;
    assign rsp.was_updated = upd_out_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg != 2'd3)
        else $error("byte count out of range");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> byte_count_reg == 2'd0)
        else $error("packet in progress while disarmed");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && is_read) |=> (!update_flag_reg && out_valid_reg))
        else $error("read did not clear flag or post response");

    a_resp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(pos_x_reg)))
        else $error("stalled response lost");

endmodule

// ----- hdl/ps2_mouse_packet_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Follows a PS/2 three-byte mouse stream and keeps a clamped pointer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one word per operation: arm (center pointer, clear packet,
//   enable), byte (one byte from the mouse) or read (report state). Only a
//   read produces a word on rsp: position, buttons and the updated flag,
//   which the read then clears. Code 3 is accepted and does nothing.
//   A packet starts with a byte that has bit 3 set; other leading bytes are
//   dropped. The third byte moves the pointer, clamped to the screen.
// Configuration:
//   cfg_write/cfg_index/cfg_data write screen_width (0) or screen_height (1);
//   write only while no command is in flight.
// Timing:
//   One word per cycle is accepted unless a read is held by a stalled rsp.
//   A command is held in the input register and executed there; a read
//   response appears on rsp in the cycle after the read is executed.
// Reset and stall:
//   Reset disarms the block, zeroes pointer, buttons and flag, and loads the
//   default screen size of 640 by 480. While rsp is stalled, non-read words
//   keep flowing; a second read waits in the input register until the
//   pending response is taken.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker
    import pmt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]    cfg_data,
    pmt_in_if.sink                  cmd,
    pmt_out_if.source               rsp
);

    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;
    item_t                item;
    logic                 item_valid;
    logic                 item_take;

    // Hold the screen size registers; update on a configuration write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Capture the command word.
    pmt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // Execute it and register any read response.
    pmt_tracker u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_take     (item_take),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .rsp           (rsp)
    );

endmodule
